// ===== design/bone_weight_top_k_normalize_assert.svh =====
// Assertion macros used by the bone weight normalizer checker.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef BONE_WEIGHT_TOP_K_NORMALIZE_ASSERT_SVH
`define BONE_WEIGHT_TOP_K_NORMALIZE_ASSERT_SVH

// Condition holds at every clock edge out of reset.
`define BWTK_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define BWTK_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== design/bwtk_pkg.sv =====
// Shared constants, field types and register codes of the bone weight normalizer.
// No dependencies.
`timescale 1ns / 1ps

package bwtk_pkg;

    localparam int SLOTS      = 4;
    localparam int ID_W       = 8;
    localparam int WT_W       = 16;
    localparam int NW_W       = WT_W + 1;
    localparam int SUM_W      = WT_W + $clog2(SLOTS);
    localparam int REM_W      = SUM_W + 1;
    localparam int RANK_W     = $clog2(SLOTS);
    localparam int KEEP_W     = 3;
    localparam int DIV_STAGES = NW_W;
    localparam int LATENCY    = DIV_STAGES + 2;
    localparam int UNITY      = 1 << WT_W;

    localparam int ADDR_W     = 3;
    localparam int DATA_W     = 32;
    localparam int WIDX_W     = ADDR_W - 2;

    localparam logic [WIDX_W-1:0] REG_MAX_BONES   = '0;
    localparam logic [KEEP_W-1:0] MAX_BONES_RESET = KEEP_W'(SLOTS);

    typedef logic [ID_W-1:0]   id_t;
    typedef logic [WT_W-1:0]   wt_t;
    typedef logic [NW_W-1:0]   nw_t;
    typedef logic [SUM_W-1:0]  sum_t;
    typedef logic [RANK_W-1:0] rank_t;
    typedef logic [KEEP_W-1:0] keep_t;

    typedef logic [SLOTS-1:0][ID_W-1:0]   id_vec_t;
    typedef logic [SLOTS-1:0][WT_W-1:0]   wt_vec_t;
    typedef logic [SLOTS-1:0][RANK_W-1:0] rank_vec_t;

endpackage

// ===== design/bwtk_rank_lane.sv =====
// One ranking lane: counts how many slots sort ahead of its own slot.
// Depends on bwtk_pkg.
`timescale 1ns / 1ps

module bwtk_rank_lane (
    input  bwtk_pkg::wt_vec_t weights,
    input  bwtk_pkg::rank_t   slot,
    output bwtk_pkg::rank_t   rank
);
    import bwtk_pkg::*;

    always_comb
    begin
        rank_t cnt;
        wt_t   mine;
        mine = weights[slot];
        cnt  = '0;
        for (int j = 0; j < SLOTS; j++)
        begin
            // heavier first, lower slot wins a tie
            if ((weights[j] > mine) || ((weights[j] == mine) && (RANK_W'(j) < slot)))
            begin
                cnt = cnt + 1'b1;
            end
        end
        rank = cnt;
    end

endmodule

// ===== design/bwtk_merge.sv =====
// Merge stage: places each slot at its rank, drops positions past the kept
// count and sums the kept weights. Depends on bwtk_pkg.
`timescale 1ns / 1ps

module bwtk_merge (
    input  bwtk_pkg::id_vec_t   ids,
    input  bwtk_pkg::wt_vec_t   weights,
    input  bwtk_pkg::rank_vec_t ranks,
    input  bwtk_pkg::keep_t     max_bones,
    output bwtk_pkg::id_vec_t   sorted_ids,
    output bwtk_pkg::wt_vec_t   sorted_weights,
    output bwtk_pkg::sum_t      sum
);
    import bwtk_pkg::*;

    keep_t keep;

    always_comb
    begin
        if (max_bones == '0)
        begin
            keep = KEEP_W'(1);
        end
        else if (max_bones > KEEP_W'(SLOTS))
        begin
            keep = KEEP_W'(SLOTS);
        end
        else
        begin
            keep = max_bones;
        end
    end

    always_comb
    begin
        sorted_ids     = '0;
        sorted_weights = '0;
        sum            = '0;
        for (int p = 0; p < SLOTS; p++)
        begin
            // ranks form a permutation, so exactly one slot hits each position
            for (int i = 0; i < SLOTS; i++)
            begin
                if (ranks[i] == RANK_W'(p))
                begin
                    sorted_ids[p]     = sorted_ids[p] | ids[i];
                    sorted_weights[p] = sorted_weights[p] | weights[i];
                end
            end
            if (KEEP_W'(p) >= keep)
            begin
                sorted_ids[p]     = '0;
                sorted_weights[p] = '0;
            end
            sum = sum + SUM_W'(sorted_weights[p]);
        end
    end

endmodule

// ===== design/bwtk_div_lane.sv =====
// Pipelined restoring divider lane: w * 65536 / divisor, one quotient bit per
// stage, floor rounding. Depends on bwtk_pkg.
`timescale 1ns / 1ps

module bwtk_div_lane (
    input  logic           clk,
    input  bwtk_pkg::wt_t  w,
    input  bwtk_pkg::sum_t divisor,
    output bwtk_pkg::nw_t  quo
);
    import bwtk_pkg::*;

    sum_t rem_reg [DIV_STAGES];
    sum_t div_reg [DIV_STAGES];
    nw_t  quo_reg [DIV_STAGES];

    sum_t             rem_next [DIV_STAGES];
    nw_t              quo_next [DIV_STAGES];
    logic [REM_W-1:0] shifted  [DIV_STAGES];
    logic [REM_W-1:0] diff     [DIV_STAGES];
    sum_t             dv       [DIV_STAGES];
    nw_t              qp       [DIV_STAGES];
    logic             ge       [DIV_STAGES];

    always_comb
    begin
        // first stage sees the upper half of w * 65536, which never exceeds the divisor
        shifted[0] = REM_W'(w);
        dv[0]      = divisor;
        qp[0]      = '0;
        for (int k = 1; k < DIV_STAGES; k++)
        begin
            shifted[k] = {rem_reg[k-1], 1'b0};
            dv[k]      = div_reg[k-1];
            qp[k]      = quo_reg[k-1];
        end
        for (int k = 0; k < DIV_STAGES; k++)
        begin
            diff[k]     = shifted[k] - {1'b0, dv[k]};
            ge[k]       = (shifted[k] >= {1'b0, dv[k]});
            rem_next[k] = ge[k] ? diff[k][SUM_W-1:0] : shifted[k][SUM_W-1:0];
            quo_next[k] = {qp[k][NW_W-2:0], ge[k]};
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < DIV_STAGES; k++)
        begin
            rem_reg[k] <= rem_next[k];
            div_reg[k] <= dv[k];
            quo_reg[k] <= quo_next[k];
        end
    end

    assign quo = quo_reg[DIV_STAGES-1];

endmodule

// ===== design/bone_weight_top_k_normalize.sv =====
// Top level of the bone weight top-k normalizer: APB register, rank lanes,
// merge stage and divider lanes. Depends on bwtk_pkg and the bwtk_* modules.
`timescale 1ns / 1ps

// One vertex enters per clock whenever start is high; busy never rises. Each
// vertex's result sits on the sorted_id and norm_weight ports for a single cycle
// with done high: the receiver cannot stall the block. Each result passes
// through one ranking stage, one merge stage and the divider lanes, a 17-stage
// restoring pipeline per output position that resolves one quotient bit per
// stage. max_bones sits at byte address 0; the user must keep it written only
// while no vertex is in flight, as the block itself does not enforce this.
module bone_weight_top_k_normalize (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bwtk_pkg::ADDR_W-1:0]   paddr,
    input  logic [bwtk_pkg::DATA_W-1:0]   pwdata,
    output logic [bwtk_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    input  logic                          start,
    output logic                          busy,
    input  bwtk_pkg::id_t                 bone_id_0,
    input  bwtk_pkg::id_t                 bone_id_1,
    input  bwtk_pkg::id_t                 bone_id_2,
    input  bwtk_pkg::id_t                 bone_id_3,
    input  bwtk_pkg::wt_t                 weight_in_0,
    input  bwtk_pkg::wt_t                 weight_in_1,
    input  bwtk_pkg::wt_t                 weight_in_2,
    input  bwtk_pkg::wt_t                 weight_in_3,
    output logic                          done,
    output bwtk_pkg::id_t                 sorted_id_0,
    output bwtk_pkg::id_t                 sorted_id_1,
    output bwtk_pkg::id_t                 sorted_id_2,
    output bwtk_pkg::id_t                 sorted_id_3,
    output bwtk_pkg::nw_t                 norm_weight_0,
    output bwtk_pkg::nw_t                 norm_weight_1,
    output bwtk_pkg::nw_t                 norm_weight_2,
    output bwtk_pkg::nw_t                 norm_weight_3
);
    import bwtk_pkg::*;

    // ---------------- configuration ----------------
    keep_t max_bones_reg;
    logic  cfg_write;
    logic  cfg_hit;

    assign pready    = 1'b1;
    assign cfg_hit   = (paddr[ADDR_W-1:2] == REG_MAX_BONES);
    assign cfg_write = psel && penable && pwrite && pready && cfg_hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_bones_reg <= MAX_BONES_RESET;
        end
        else if (cfg_write)
        begin
            max_bones_reg <= pwdata[KEEP_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (cfg_hit)
        begin
            prdata = DATA_W'(max_bones_reg);
        end
    end

    // ---------------- input and ranking ----------------
    id_vec_t   ids_in;
    wt_vec_t   weights_in;
    rank_vec_t rank_next;
    logic      accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign ids_in     = {bone_id_3, bone_id_2, bone_id_1, bone_id_0};
    assign weights_in = {weight_in_3, weight_in_2, weight_in_1, weight_in_0};

    for (genvar i = 0; i < SLOTS; i++)
    begin : g_rank
        bwtk_rank_lane u_rank (
            .weights (weights_in),
            .slot    (RANK_W'(i)),
            .rank    (rank_next[i])
        );
    end

    logic      valid_s1_reg;
    id_vec_t   ids_s1_reg;
    wt_vec_t   weights_s1_reg;
    rank_vec_t ranks_s1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_s1_reg <= 1'b0;
        end
        else
        begin
            valid_s1_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        ids_s1_reg     <= ids_in;
        weights_s1_reg <= weights_in;
        ranks_s1_reg   <= rank_next;
    end

    // ---------------- merge ----------------
    id_vec_t sids_next;
    wt_vec_t sws_next;
    sum_t    sum_next;

    bwtk_merge u_merge (
        .ids            (ids_s1_reg),
        .weights        (weights_s1_reg),
        .ranks          (ranks_s1_reg),
        .max_bones      (max_bones_reg),
        .sorted_ids     (sids_next),
        .sorted_weights (sws_next),
        .sum            (sum_next)
    );

    logic    valid_s2_reg;
    id_vec_t sids_s2_reg;
    wt_vec_t sws_s2_reg;
    sum_t    sum_s2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_s2_reg <= 1'b0;
        end
        else
        begin
            valid_s2_reg <= valid_s1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sids_s2_reg <= sids_next;
        sws_s2_reg  <= sws_next;
        sum_s2_reg  <= sum_next;
    end

    // ---------------- division ----------------
    logic    valid_pipe_reg [DIV_STAGES];
    id_vec_t ids_pipe_reg   [DIV_STAGES];
    logic    nz_pipe_reg    [DIV_STAGES];
    nw_t     quo            [SLOTS];

    for (genvar i = 0; i < SLOTS; i++)
    begin : g_div
        bwtk_div_lane u_div (
            .clk     (clk),
            .w       (sws_s2_reg[i]),
            .divisor (sum_s2_reg),
            .quo     (quo[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < DIV_STAGES; k++)
            begin
                valid_pipe_reg[k] <= 1'b0;
            end
        end
        else
        begin
            valid_pipe_reg[0] <= valid_s2_reg;
            for (int k = 1; k < DIV_STAGES; k++)
            begin
                valid_pipe_reg[k] <= valid_pipe_reg[k-1];
            end
        end
    end

    // carry ids and the nonzero-sum flag alongside the divider stages
    always_ff @(posedge clk)
    begin
        ids_pipe_reg[0] <= sids_s2_reg;
        nz_pipe_reg[0]  <= (sum_s2_reg != '0);
        for (int k = 1; k < DIV_STAGES; k++)
        begin
            ids_pipe_reg[k] <= ids_pipe_reg[k-1];
            nz_pipe_reg[k]  <= nz_pipe_reg[k-1];
        end
    end

    // ---------------- result beat ----------------
    nw_t nw_out [SLOTS];

    always_comb
    begin
        for (int p = 0; p < SLOTS; p++)
        begin
            // a zero sum leaves every weight at zero
            nw_out[p] = nz_pipe_reg[DIV_STAGES-1] ? quo[p] : '0;
        end
    end

    assign done          = valid_pipe_reg[DIV_STAGES-1];
    assign sorted_id_0   = ids_pipe_reg[DIV_STAGES-1][0];
    assign sorted_id_1   = ids_pipe_reg[DIV_STAGES-1][1];
    assign sorted_id_2   = ids_pipe_reg[DIV_STAGES-1][2];
    assign sorted_id_3   = ids_pipe_reg[DIV_STAGES-1][3];
    assign norm_weight_0 = nw_out[0];
    assign norm_weight_1 = nw_out[1];
    assign norm_weight_2 = nw_out[2];
    assign norm_weight_3 = nw_out[3];

endmodule

// ===== design/bwtk_checker.sv =====
// Port-level checker for the bone weight normalizer, bound to the top level.
// Depends on bwtk_pkg and bone_weight_top_k_normalize_assert.svh.
`timescale 1ns / 1ps
`include "bone_weight_top_k_normalize_assert.svh"

module bwtk_checker (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic          busy,
    input  logic          done,
    input  bwtk_pkg::nw_t norm_weight_0,
    input  bwtk_pkg::nw_t norm_weight_1,
    input  bwtk_pkg::nw_t norm_weight_2,
    input  bwtk_pkg::nw_t norm_weight_3
);
    import bwtk_pkg::*;

    logic [NW_W+1:0] total;
    logic            accept;
    logic            ordered;

    assign total = (NW_W+2)'(norm_weight_0) + (NW_W+2)'(norm_weight_1)
                 + (NW_W+2)'(norm_weight_2) + (NW_W+2)'(norm_weight_3);

    assign accept  = start && !busy;
    assign ordered = (norm_weight_0 >= norm_weight_1) && (norm_weight_1 >= norm_weight_2)
                   && (norm_weight_2 >= norm_weight_3);

    // the pipeline never stalls
    `BWTK_ASSERT_ALWAYS(a_never_busy, !busy, "busy raised")

    // every result beat traces back to an accepted vertex
    `BWTK_ASSERT_IMPL(a_done_latency, done, $past(accept, LATENCY), "done without vertex")

    // floor scaling keeps the descending order of the sorted weights
    `BWTK_ASSERT_IMPL(a_weights_ordered, done, ordered, "weights out of order")

    // rounded-down shares never add up past one
    `BWTK_ASSERT_IMPL(a_weight_total, done, total <= (NW_W+2)'(UNITY), "weights exceed one")

endmodule

bind bone_weight_top_k_normalize bwtk_checker u_bwtk_checker (.*);
